/* sv/urc_pkg.sv */
// Shared types, register indexes and reset values of the ultrasonic range controller.
package urc_pkg;

    localparam int COUNT_BITS_DEF    = 17;
    localparam int DISTANCE_BITS_DEF = 10;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;

    localparam int TRIG_WIDTH_BITS = 8;
    localparam int TIMEOUT_BITS    = 16;
    localparam int DELAY_BITS      = 17;
    localparam int MAX_DIST_BITS   = 10;
    localparam int SCALE_BITS      = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TRIGGER_WIDTH = 3'd0,
        CFG_TIMEOUT       = 3'd1,
        CFG_GAP           = 3'd2,
        CFG_SETTLE        = 3'd3,
        CFG_MAX_DISTANCE  = 3'd4,
        CFG_SCALE         = 3'd5
    } cfg_index_t;

    localparam logic [TRIG_WIDTH_BITS-1:0] TRIG_WIDTH_RST = 8'd10;
    localparam logic [TIMEOUT_BITS-1:0]    TIMEOUT_RST    = 16'd30000;
    localparam logic [DELAY_BITS-1:0]      GAP_RST        = 17'd60000;
    localparam logic [DELAY_BITS-1:0]      SETTLE_RST     = 17'd100000;
    localparam logic [MAX_DIST_BITS-1:0]   MAX_DIST_RST   = 10'd400;
    localparam logic [SCALE_BITS-1:0]      SCALE_RST      = 16'd1124;

    typedef enum logic [2:0] {
        PH_SETTLE = 3'd0,
        PH_TRIG   = 3'd1,
        PH_RISE   = 3'd2,
        PH_HIGH   = 3'd3,
        PH_GAP    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_NO_RISE  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

endpackage

/* sv/ultrasonic_range_controller_unit.sv */
// Top level of the ultrasonic range controller: sequencer, scaling and result register.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+---------------------------------------
//  sample   | in        | sample_valid / sample_stall | echo_level
//  result   | out       | result_valid / result_stall | trigger_level, distance_cm,
//           |           |                            | measure_done, result_status
//  cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Every accepted sample beat is one microsecond tick and yields exactly one result beat.
// A tick is worked out combinationally: the phase sequencer, the 16 x 16 scaling multiply
// and the range compare sit between the state registers and the result register, so one
// sample beat can be taken in every cycle while the sample side does not stall.
// The sample side stalls only while a finished result waits and the result side stalls;
// a result taken in the same cycle frees the register for the next beat.
// Reset puts the sequencer in the settle phase with a zero tick count and zero distance,
// and loads the configuration registers with their default values.
module ultrasonic_range_controller_unit #(
    parameter int COUNT_BITS    = urc_pkg::COUNT_BITS_DEF,
    parameter int DISTANCE_BITS = urc_pkg::DISTANCE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                echo_level,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                trigger_level,
    output logic [DISTANCE_BITS-1:0]            distance_cm,
    output logic                                measure_done,
    output logic [1:0]                          result_status,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [urc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [urc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    // Configuration registers. Writes are always taken; an unused index is dropped.
    logic [urc_pkg::TRIG_WIDTH_BITS-1:0] trig_width_reg;
    logic [urc_pkg::TIMEOUT_BITS-1:0]    timeout_reg;
    logic [urc_pkg::DELAY_BITS-1:0]      gap_reg;
    logic [urc_pkg::DELAY_BITS-1:0]      settle_reg;
    logic [urc_pkg::MAX_DIST_BITS-1:0]   max_dist_reg;
    logic [urc_pkg::SCALE_BITS-1:0]      scale_reg;

    // Sequencer state.
    urc_pkg::phase_t                     phase_reg;
    urc_pkg::phase_t                     phase_next;
    logic [COUNT_BITS-1:0]               tick_count_reg;
    logic [COUNT_BITS-1:0]               tick_count_next;
    logic [DISTANCE_BITS-1:0]            held_dist_reg;
    logic [DISTANCE_BITS-1:0]            held_dist_next;

    // Result register.
    logic                                result_valid_reg;
    logic                                trigger_reg;
    logic                                trigger_next;
    logic [DISTANCE_BITS-1:0]            distance_reg;
    logic                                done_reg;
    logic                                done_next;
    urc_pkg::status_t                    status_reg;
    urc_pkg::status_t                    status_next;

    logic                                accept;
    logic [31:0]                         product;
    logic [15:0]                         dist_scaled;

    localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    // Saturating increment of the tick counter.
    function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] v);
        inc_sat = (&v) ? v : v + CNT_ONE;
    endfunction

    assign cfg_ready    = 1'b1;
    assign accept       = sample_valid && !sample_stall;
    // The result register is free unless a result waits and is held back this cycle.
    assign sample_stall = result_valid_reg && result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width_reg <= urc_pkg::TRIG_WIDTH_RST;
            timeout_reg    <= urc_pkg::TIMEOUT_RST;
            gap_reg        <= urc_pkg::GAP_RST;
            settle_reg     <= urc_pkg::SETTLE_RST;
            max_dist_reg   <= urc_pkg::MAX_DIST_RST;
            scale_reg      <= urc_pkg::SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                urc_pkg::CFG_TRIGGER_WIDTH: trig_width_reg <= cfg_data[7:0];
                urc_pkg::CFG_TIMEOUT:       timeout_reg    <= cfg_data[15:0];
                urc_pkg::CFG_GAP:           gap_reg        <= cfg_data[16:0];
                urc_pkg::CFG_SETTLE:        settle_reg     <= cfg_data[16:0];
                urc_pkg::CFG_MAX_DISTANCE:  max_dist_reg   <= cfg_data[9:0];
                urc_pkg::CFG_SCALE:         scale_reg      <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    // The echo width never exceeds the 16-bit timeout while in the high phase,
    // so the low 16 bits of the counter carry the whole width into the multiply.
    assign product     = 32'(tick_count_reg[15:0]) * 32'(scale_reg);
    assign dist_scaled = product[31:16];

    // One tick of the measurement sequence. The settle and gap phases may hand
    // over to the trigger phase within the same tick, so the phase is worked
    // through in order with a running copy.
    always_comb
    begin
        urc_pkg::phase_t             ph;
        logic [COUNT_BITS-1:0]       cnt;
        logic [urc_pkg::DELAY_BITS-1:0]      limit;
        logic [urc_pkg::TRIG_WIDTH_BITS-1:0] width;

        ph           = phase_reg;
        cnt          = tick_count_reg;
        trigger_next = 1'b0;
        done_next    = 1'b0;
        status_next  = urc_pkg::ST_VALID;
        held_dist_next = held_dist_reg;
        limit        = settle_reg;
        width        = (trig_width_reg == '0) ? 8'd1 : trig_width_reg;

        unique case (phase_reg)
            urc_pkg::PH_SETTLE, urc_pkg::PH_TRIG, urc_pkg::PH_RISE,
            urc_pkg::PH_HIGH, urc_pkg::PH_GAP: ;
            default:
            begin
                ph  = urc_pkg::PH_SETTLE;
                cnt = '0;
            end
        endcase

        if (ph == urc_pkg::PH_SETTLE || ph == urc_pkg::PH_GAP)
        begin
            limit = (ph == urc_pkg::PH_SETTLE) ? settle_reg : gap_reg;
            if (32'(cnt) >= 32'(limit))
            begin
                ph  = urc_pkg::PH_TRIG;
                cnt = '0;
            end
            else
            begin
                cnt = inc_sat(cnt);
            end
        end

        if (ph == urc_pkg::PH_TRIG)
        begin
            trigger_next = 1'b1;
            cnt          = inc_sat(cnt);
            if (32'(cnt) >= 32'(width))
            begin
                ph  = urc_pkg::PH_RISE;
                cnt = '0;
            end
        end
        else if (ph == urc_pkg::PH_RISE)
        begin
            if (echo_level)
            begin
                ph  = urc_pkg::PH_HIGH;
                cnt = CNT_ONE;
                if (timeout_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = urc_pkg::ST_TOO_LONG;
                end
            end
            else
            begin
                cnt = inc_sat(cnt);
                if (32'(cnt) > 32'(timeout_reg))
                begin
                    done_next   = 1'b1;
                    status_next = urc_pkg::ST_NO_RISE;
                end
            end
        end
        else if (ph == urc_pkg::PH_HIGH)
        begin
            if (echo_level)
            begin
                cnt = inc_sat(cnt);
                if (32'(cnt) > 32'(timeout_reg))
                begin
                    done_next   = 1'b1;
                    status_next = urc_pkg::ST_TOO_LONG;
                end
            end
            else
            begin
                done_next = 1'b1;
                if (dist_scaled > 16'(max_dist_reg))
                begin
                    status_next = urc_pkg::ST_RANGE;
                end
                else
                begin
                    held_dist_next = dist_scaled[DISTANCE_BITS-1:0];
                end
            end
        end

        if (done_next)
        begin
            ph  = urc_pkg::PH_GAP;
            cnt = '0;
        end

        phase_next      = ph;
        tick_count_next = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= urc_pkg::PH_SETTLE;
            tick_count_reg   <= '0;
            held_dist_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                tick_count_reg   <= tick_count_next;
                held_dist_reg    <= held_dist_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; only meaningful while result_valid is high.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trigger_reg  <= trigger_next;
            distance_reg <= held_dist_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign trigger_level = trigger_reg;
    assign distance_cm   = distance_reg;
    assign measure_done  = done_reg;
    assign result_status = status_reg;

endmodule

/* sv/urc_checker.sv */
// Port-level checker for the ultrasonic range controller, bound to the top level.
module urc_checker #(
    parameter int DISTANCE_BITS = urc_pkg::DISTANCE_BITS_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_stall,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic                     trigger_level,
    input logic [DISTANCE_BITS-1:0] distance_cm,
    input logic                     measure_done,
    input logic [1:0]               result_status
);

    // A held result keeps its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(distance_cm)
            && $stable(measure_done) && $stable(result_status))
        else $error("stalled result beat changed");

    // The sample side only stalls behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample stalled without a waiting result");

    // Status is only reported on the tick that ends an attempt.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !measure_done |-> result_status == urc_pkg::ST_VALID)
        else $error("status set without a finished attempt");

    // The trigger is never high on the tick that ends a measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(trigger_level && measure_done))
        else $error("trigger high while a measurement ends");

endmodule

bind ultrasonic_range_controller_unit urc_checker #(
    .DISTANCE_BITS (DISTANCE_BITS)
) u_urc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_stall  (sample_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .trigger_level (trigger_level),
    .distance_cm   (distance_cm),
    .measure_done  (measure_done),
    .result_status (result_status)
);

/* sim/tb_ultrasonic_range_controller_unit.sv */
// Self-checking testbench of the ultrasonic range controller with its tick scoreboard.
`timescale 1ns / 1ps

module tb_ultrasonic_range_controller_unit;

    localparam int DIST_W = urc_pkg::DISTANCE_BITS_DEF;
    localparam int CNT_W  = urc_pkg::COUNT_BITS_DEF;
    localparam int CFG_W  = urc_pkg::CFG_DATA_BITS;

    // Cycles without any beat on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [urc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [urc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // One result beat as seen on the result channel.
    typedef struct packed {
        logic              trigger;
        logic [DIST_W-1:0] distance;
        logic              done;
        urc_pkg::status_t  status;
    } tick_result_t;

    // Tick-accurate copy of the range sequencer. Every accepted sample beat advances
    // the copy by one microsecond and queues the result beat that it must produce.
    class range_tick_model;
        urc_pkg::phase_t                     phase;
        logic [CNT_W-1:0]                    tick_count;
        logic [DIST_W-1:0]                   held_distance;
        logic [urc_pkg::TRIG_WIDTH_BITS-1:0] trigger_width;
        logic [urc_pkg::TIMEOUT_BITS-1:0]    timeout;
        logic [urc_pkg::DELAY_BITS-1:0]      gap;
        logic [urc_pkg::DELAY_BITS-1:0]      settle;
        logic [urc_pkg::MAX_DIST_BITS-1:0]   dist_limit;
        logic [urc_pkg::SCALE_BITS-1:0]      scale;
        tick_result_t                        expected_ticks[$];
        int                                  errors;
        int                                  ticks_seen;
        int                                  status_hits[4];

        function new();
            phase         = urc_pkg::PH_SETTLE;
            tick_count    = '0;
            held_distance = '0;
            trigger_width = urc_pkg::TRIG_WIDTH_RST;
            timeout       = urc_pkg::TIMEOUT_RST;
            gap           = urc_pkg::GAP_RST;
            settle        = urc_pkg::SETTLE_RST;
            dist_limit    = urc_pkg::MAX_DIST_RST;
            scale         = urc_pkg::SCALE_RST;
            errors        = 0;
            ticks_seen    = 0;
            status_hits   = '{0, 0, 0, 0};
        endfunction

        function void write_reg(logic [urc_pkg::CFG_INDEX_BITS-1:0] index,
                                logic [urc_pkg::CFG_DATA_BITS-1:0] value);
            case (index)
                urc_pkg::CFG_TRIGGER_WIDTH:
                    trigger_width = value[urc_pkg::TRIG_WIDTH_BITS-1:0];
                urc_pkg::CFG_TIMEOUT:      timeout    = value[urc_pkg::TIMEOUT_BITS-1:0];
                urc_pkg::CFG_GAP:          gap        = value[urc_pkg::DELAY_BITS-1:0];
                urc_pkg::CFG_SETTLE:       settle     = value[urc_pkg::DELAY_BITS-1:0];
                urc_pkg::CFG_MAX_DISTANCE: dist_limit = value[urc_pkg::MAX_DIST_BITS-1:0];
                urc_pkg::CFG_SCALE:        scale      = value[urc_pkg::SCALE_BITS-1:0];
                default:                   ;
            endcase
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] count);
            return (&count) ? count : count + 1'b1;
        endfunction

        // Advances one tick and returns whether this tick ends a measurement attempt.
        function bit note_tick(bit echo);
            tick_result_t     r;
            logic [CNT_W-1:0] limit;
            logic [CNT_W-1:0] width;
            logic [47:0]      product;
            r.trigger = 1'b0;
            r.done    = 1'b0;
            r.status  = urc_pkg::ST_VALID;
            // A delay that has run out hands over to the trigger on the same tick.
            if (phase == urc_pkg::PH_SETTLE || phase == urc_pkg::PH_GAP)
            begin
                limit = (phase == urc_pkg::PH_SETTLE) ? settle : gap;
                if (tick_count >= limit)
                begin
                    phase      = urc_pkg::PH_TRIG;
                    tick_count = '0;
                end
                else
                begin
                    tick_count = bump(tick_count);
                end
            end
            case (phase)
                urc_pkg::PH_TRIG:
                begin
                    width      = (trigger_width == '0) ? CNT_W'(1) : CNT_W'(trigger_width);
                    r.trigger  = 1'b1;
                    tick_count = bump(tick_count);
                    if (tick_count >= width)
                    begin
                        phase      = urc_pkg::PH_RISE;
                        tick_count = '0;
                    end
                end
                urc_pkg::PH_RISE:
                begin
                    if (echo)
                    begin
                        // The rise tick already counts as one tick of high width.
                        phase      = urc_pkg::PH_HIGH;
                        tick_count = CNT_W'(1);
                        if (tick_count > timeout)
                        begin
                            r.done   = 1'b1;
                            r.status = urc_pkg::ST_TOO_LONG;
                        end
                    end
                    else
                    begin
                        tick_count = bump(tick_count);
                        if (tick_count > timeout)
                        begin
                            r.done   = 1'b1;
                            r.status = urc_pkg::ST_NO_RISE;
                        end
                    end
                end
                urc_pkg::PH_HIGH:
                begin
                    if (echo)
                    begin
                        tick_count = bump(tick_count);
                        if (tick_count > timeout)
                        begin
                            r.done   = 1'b1;
                            r.status = urc_pkg::ST_TOO_LONG;
                        end
                    end
                    else
                    begin
                        product = tick_count * scale;
                        r.done  = 1'b1;
                        if (product[47:16] > dist_limit)
                            r.status = urc_pkg::ST_RANGE;
                        else
                            held_distance = product[16 +: DIST_W];
                    end
                end
                default: ;
            endcase
            if (r.done)
            begin
                phase      = urc_pkg::PH_GAP;
                tick_count = '0;
            end
            r.distance = held_distance;
            expected_ticks.push_back(r);
            return r.done;
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            ticks_seen++;
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            if (got.trigger !== want.trigger)
            begin
                $display("%0t: trigger_level expected %0d actual %0d",
                         $time, want.trigger, got.trigger);
                errors++;
            end
            if (got.distance !== want.distance)
            begin
                $display("%0t: distance_cm expected %0d actual %0d",
                         $time, want.distance, got.distance);
                errors++;
            end
            if (got.done !== want.done)
            begin
                $display("%0t: measure_done expected %0d actual %0d",
                         $time, want.done, got.done);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: result_status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (want.done)
                status_hits[want.status]++;
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n        = 1'b0;
    logic                               sample_valid = 1'b0;
    logic                               sample_stall;
    logic                               echo_level   = 1'b0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic                               trigger_level;
    logic [DIST_W-1:0]                  distance_cm;
    logic                               measure_done;
    logic [1:0]                         result_status;
    logic                               cfg_valid    = 1'b0;
    logic                               cfg_ready;
    logic [urc_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]                   cfg_data     = '0;

    range_tick_model model;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Sample beats sent while the block waits for or measures the echo.
    int echo_ticks = 0;

    ultrasonic_range_controller_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .echo_level    (echo_level),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .trigger_level (trigger_level),
        .distance_cm   (distance_cm),
        .measure_done  (measure_done),
        .result_status (result_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: values are sampled at the edge before the block updates them, and
    // the stall for the next cycle is drawn independently of the valid.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            model.check_result(tick_result_t'({trigger_level, distance_cm,
                                                measure_done, result_status}));
        result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Hang detector: any accepted beat on any channel restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // Sends one tick. Valid stays high after the beat so that back-to-back ticks do
    // not toggle it; whoever sends nothing next must lower it in the same time step.
    task automatic send_tick(input bit echo, output bit done);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        echo_level   <= echo;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        done = model.note_tick(echo);
    endtask

    // Drives ticks until one measurement attempt ends. The echo follows the phase of
    // the model: rise_wait low ticks, then high_len high ticks counting the rise tick,
    // then low. Outside the echo phases, and in noisy attempts, the echo is random.
    task automatic run_attempt(input int rise_wait, input int high_len, input bit noisy);
        bit done;
        bit echo;
        int rw;
        int hl;
        done = 1'b0;
        rw   = rise_wait;
        hl   = high_len;
        while (!done)
        begin
            case (model.phase)
                urc_pkg::PH_RISE:
                begin
                    echo = noisy ? bit'($urandom_range(0, 1)) : (rw == 0);
                    if (rw > 0)
                        rw--;
                    else
                        hl--;
                    echo_ticks++;
                end
                urc_pkg::PH_HIGH:
                begin
                    echo = noisy ? bit'($urandom_range(0, 1)) : (hl > 0);
                    if (hl > 0)
                        hl--;
                    echo_ticks++;
                end
                default: echo = bit'($urandom_range(0, 1));
            endcase
            send_tick(echo, done);
        end
    endtask

    // Stops the sample channel and waits until every queued result beat has arrived.
    // Each tick causes exactly one result, so the block is idle afterwards.
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (model.expected_ticks.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [urc_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model.write_reg(index, value);
    endtask

    // Loads a full register set while the block is idle. The spare indexes are
    // optionally written too, which must leave every register untouched.
    task automatic load_setting(input int trig, input int timeout, input int gap,
                                input int settle, input int max_dist, input int scale,
                                input bit poke_spare);
        drain_results();
        cfg_write(urc_pkg::CFG_TRIGGER_WIDTH, CFG_W'(trig));
        cfg_write(urc_pkg::CFG_TIMEOUT, CFG_W'(timeout));
        cfg_write(urc_pkg::CFG_GAP, CFG_W'(gap));
        cfg_write(urc_pkg::CFG_SETTLE, CFG_W'(settle));
        cfg_write(urc_pkg::CFG_MAX_DISTANCE, CFG_W'(max_dist));
        cfg_write(urc_pkg::CFG_SCALE, CFG_W'(scale));
        if (poke_spare)
        begin
            cfg_write(CFG_SPARE_LO, CFG_W'($urandom_range(0, 131071)));
            cfg_write(CFG_SPARE_HI, CFG_W'($urandom_range(0, 131071)));
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int p;
        int r;
        int target;
        int timeout;
        int scale;
        int max_dist;
        int span;
        int trig;
        model = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: zero trigger width, zero gap and a tight timeout of three
        // ticks. With full scale a width of w ticks gives w - 1 cm, so with a limit of
        // one centimetre the four attempts end valid, out of range, with the echo too
        // long and with no echo rise.
        load_setting(0, 3, 0, 2, 1, 65535, 1'b1);
        run_attempt(0, 2, 1'b0);
        run_attempt(0, 3, 1'b0);
        run_attempt(0, 10, 1'b0);
        run_attempt(10, 1, 1'b0);

        // Register extremes with no idling: the widest trigger pulse, the longest
        // timeout and the largest distance limit, with one short echo.
        load_setting(255, 65535, 0, 131071, 1023, 65535, 1'b0);
        run_attempt(4, 20, 1'b0);

        // A short gap with a zero scale and zero distance limit.
        load_setting(1, 5, 40, 0, 0, 0, 1'b0);
        run_attempt(2, 3, 1'b0);

        // Random part: each phase has its own register set and one of four idle mixes.
        for (p = 0; p < 8; p++)
        begin
            timeout = (p == 5) ? $urandom_range(50, 100) : $urandom_range(1, 48);
            scale   = (p == 0) ? 65535 : (p == 2) ? 0 : $urandom_range(1, 65535);
            span    = (timeout * scale) >> 16;
            if (span > 1023)
                span = 1023;
            max_dist = (p == 2 || p == 6) ? 0 : (p == 7) ? 1023 : $urandom_range(0, span);
            trig     = (p == 3) ? 0 : $urandom_range(1, 8);
            load_setting(trig, timeout, $urandom_range(0, 6), $urandom_range(0, 131071),
                         max_dist, scale, 1'b0);
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 50;
                end
                default:
                begin
                    sender_idle_pct    = 36;
                    receiver_stall_pct = 36;
                end
            endcase
            // Mostly well-formed echoes around the limits, some missing or endless
            // echoes, and a few attempts of pure noise.
            target = echo_ticks + 20;
            while (echo_ticks < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    run_attempt($urandom_range(0, timeout), $urandom_range(1, timeout), 1'b0);
                else if (r < 70)
                    run_attempt($urandom_range(0, 3), timeout + $urandom_range(1, 3), 1'b0);
                else if (r < 85)
                    run_attempt(timeout + 1, 1, 1'b0);
                else
                    run_attempt(0, 1, 1'b1);
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (model.expected_ticks.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived",
                     $time, model.expected_ticks.size());
            model.errors++;
        end
        $display("Checked %0d result beats over directed, extreme and random register sets",
                 model.ticks_seen);
        $display("Attempts: %0d valid, %0d no rise, %0d echo too long, %0d out of range",
                 model.status_hits[urc_pkg::ST_VALID], model.status_hits[urc_pkg::ST_NO_RISE],
                 model.status_hits[urc_pkg::ST_TOO_LONG],
                 model.status_hits[urc_pkg::ST_RANGE]);
        if (model.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
